// File: hw/rtl/hmsu_pkg.sv
// Shared constants and types of the hit message stream unpacker.
package hmsu_pkg;

  localparam int unsigned SLICE_HEADER_BYTES = 16;
  localparam int unsigned PACKET_ALIGN       = 8;

  localparam int unsigned OFF_W  = (PACKET_ALIGN > 1) ? $clog2(PACKET_ALIGN) : 1;
  localparam int unsigned LEFT_W = 10;
  localparam int unsigned IDX_W  = 3;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 104;

  localparam logic [3:0] MSG_HIT   = 4'h1;
  localparam logic [3:0] MSG_EPOCH = 4'h2;

  typedef enum logic [1:0] {
    PH_SKIP = 2'd0,
    PH_HDR  = 2'd1,
    PH_BODY = 2'd2,
    PH_PAD  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [15:0] equipment_in;
    logic        slice_start;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic        overflow_flag;
    logic        pileup_flag;
    logic        last_epoch_flag;
    logic [11:0] adc_value;
    logic [13:0] timestamp;
    logic [31:0] hit_epoch;
    logic [6:0]  channel;
    logic [17:0] source_address;
    logic [15:0] equipment_id;
  } hit_t;

endpackage

// File: hw/rtl/hmsu_in_stage.sv
// Input register of the unpacker: holds one accepted byte item.
module hmsu_in_stage (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [hmsu_pkg::IN_DATA_W-1:0] s_axis_tdata,  // data_byte, equipment_in
  input  logic                           s_axis_tuser,  // slice_start
  input  logic                           proc_fire_i,
  output logic                           item_valid_o,
  output hmsu_pkg::in_item_t             item_o
);

  logic               valid_q, valid_d;
  hmsu_pkg::in_item_t item_q;
  logic               accept;

  assign s_axis_tready = !valid_q || proc_fire_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    priority if (accept) begin
      valid_d = 1'b1;
    end else if (proc_fire_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.data_byte    <= s_axis_tdata[7:0];
      item_q.equipment_in <= s_axis_tdata[23:8];
      item_q.slice_start  <= s_axis_tuser;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// File: hw/rtl/hmsu_parser.sv
// Slice and packet parser: parse state, message assembly and hit decode.
module hmsu_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               proc_fire_i,
  input  hmsu_pkg::in_item_t item_i,
  output logic               hit_valid_o,
  output hmsu_pkg::hit_t     hit_o
);

  hmsu_pkg::phase_e                  ph_q, ph_d;
  logic [hmsu_pkg::OFF_W-1:0]        off_q, off_d;
  logic [hmsu_pkg::LEFT_W-1:0]       left_q, left_d;
  logic [hmsu_pkg::IDX_W-1:0]        midx_q, midx_d;
  logic [39:0]                       mbuf_q, mbuf_d;
  logic [15:0]                       board_q, board_d;
  logic [31:0]                       epoch_q, epoch_d;
  logic [15:0]                       equip_q, equip_d;
  logic                              done;
  logic                              hit_v;
  logic [7:0]                        b, b0, b1, b2, b3, b4;

  assign b  = item_i.data_byte;
  assign b0 = mbuf_q[7:0];
  assign b1 = mbuf_q[15:8];
  assign b2 = mbuf_q[23:16];
  assign b3 = mbuf_q[31:24];
  assign b4 = mbuf_q[39:32];

  always_comb begin
    ph_d    = ph_q;
    off_d   = off_q;
    left_d  = left_q;
    midx_d  = midx_q;
    mbuf_d  = mbuf_q;
    board_d = board_q;
    epoch_d = epoch_q;
    equip_d = equip_q;
    done    = 1'b0;
    hit_v   = 1'b0;
    if (proc_fire_i) begin
      if (item_i.slice_start) begin
        ph_d    = hmsu_pkg::PH_SKIP;
        off_d   = '0;
        left_d  = '0;
        midx_d  = '0;
        equip_d = item_i.equipment_in;
      end
      if (ph_d == hmsu_pkg::PH_SKIP) begin
        if (left_d < hmsu_pkg::LEFT_W'(hmsu_pkg::SLICE_HEADER_BYTES)) begin
          left_d = left_d + 1'b1;
        end else begin
          ph_d   = hmsu_pkg::PH_HDR;
          midx_d = '0;
        end
      end
      if (ph_d == hmsu_pkg::PH_HDR) begin
        unique case (midx_d[1:0])
          2'd0: begin
            left_d = {1'b0, b, 1'b0};
            midx_d = 3'd1;
          end
          2'd1: begin
            midx_d = 3'd2;
          end
          2'd2: begin
            board_d[7:0] = b;
            midx_d       = 3'd3;
          end
          default: begin
            board_d[15:8] = b;
            midx_d        = '0;
            if (left_d == '0) begin
              done = 1'b1;
            end else begin
              ph_d = hmsu_pkg::PH_BODY;
            end
          end
        endcase
      end else if (ph_d == hmsu_pkg::PH_BODY) begin
        if (midx_d < 3'd5) begin
          unique case (midx_d)
            3'd0:    mbuf_d[7:0]   = b;
            3'd1:    mbuf_d[15:8]  = b;
            3'd2:    mbuf_d[23:16] = b;
            3'd3:    mbuf_d[31:24] = b;
            default: mbuf_d[39:32] = b;
          endcase
          midx_d = midx_d + 1'b1;
        end else begin
          if (b[3:0] == hmsu_pkg::MSG_HIT) begin
            hit_v = 1'b1;
          end else if (b[3:0] == hmsu_pkg::MSG_EPOCH) begin
            epoch_d = {b1, b2, b3, b4};
          end
          midx_d = '0;
        end
        if (left_d != '0) begin
          left_d = left_d - 1'b1;
        end
        if (left_d == '0) begin
          done = 1'b1;
        end
      end
      if (off_d == hmsu_pkg::OFF_W'(hmsu_pkg::PACKET_ALIGN - 1)) begin
        off_d = '0;
      end else begin
        off_d = off_d + 1'b1;
      end
      if (done) begin
        ph_d   = (off_d == '0) ? hmsu_pkg::PH_HDR : hmsu_pkg::PH_PAD;
        midx_d = '0;
      end else if (ph_d == hmsu_pkg::PH_PAD && off_d == '0) begin
        ph_d   = hmsu_pkg::PH_HDR;
        midx_d = '0;
      end
    end
  end

  always_comb begin
    hit_o.equipment_id    = equip_q;
    hit_o.source_address  = {board_q, b[7:6]};
    hit_o.channel         = b2[7:1];
    hit_o.hit_epoch       = epoch_q - {31'd0, b0[7]};
    hit_o.timestamp       = {b2[0], b3, b4[7:3]};
    hit_o.adc_value       = {b0[4:0], b1[7:1]};
    hit_o.last_epoch_flag = b0[7];
    hit_o.pileup_flag     = b0[5];
    hit_o.overflow_flag   = b0[6];
  end

  assign hit_valid_o = hit_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= hmsu_pkg::PH_SKIP;
      off_q   <= '0;
      left_q  <= '0;
      midx_q  <= '0;
      board_q <= '0;
      epoch_q <= '0;
      equip_q <= '0;
    end else begin
      ph_q    <= ph_d;
      off_q   <= off_d;
      left_q  <= left_d;
      midx_q  <= midx_d;
      board_q <= board_d;
      epoch_q <= epoch_d;
      equip_q <= equip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mbuf_q <= mbuf_d;
  end

endmodule

// File: hw/rtl/hmsu_out_stage.sv
// Result register of the unpacker: holds one hit item for the receiver.
module hmsu_out_stage (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            hit_load_i,
  input  hmsu_pkg::hit_t                  hit_i,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [hmsu_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic           valid_q, valid_d;
  hmsu_pkg::hit_t hit_q;

  always_comb begin
    priority if (hit_load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit_load_i) begin
      hit_q <= hit_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {2'b00, hit_q};

endmodule

// File: hw/rtl/hit_message_stream_unpacker.sv
// Top level of the hit message stream unpacker.
//
// Input channel s_axis: one slice byte per item; tuser marks the first byte
// of a slice, and the equipment id in tdata is taken with that byte.
// Output channel m_axis: one item per type 1 hit message, carrying board
// address, channel, epoch, timestamp, ADC value and flags.
// Path: a byte accepted on s_axis is held in the input register; the parser
// decodes it combinationally and a hit it ends is loaded into the result register.
// Throughput: one byte per cycle while the receiver takes each waiting hit, set by
// the combinational parser between the input register and the result register.
// Reset: parser starts in slice header skip as if a slice with equipment
// id 0 began; epoch and board id clear to zero. The epoch survives slices.
// Stall: a waiting hit holds in the result register and no byte is parsed
// until the receiver takes it; the input register holds one more byte,
// then s_axis_tready drops.
module hit_message_stream_unpacker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [hmsu_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // data_byte, equipment_in
  input  logic                            s_axis_tuser,  // slice_start
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // equipment_id, source_address, channel, hit_epoch, timestamp, adc_value,
  // last_epoch_flag, pileup_flag, overflow_flag, zero fill
  output logic [hmsu_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic               item_valid;
  hmsu_pkg::in_item_t item;
  logic               proc_fire;
  logic               hit_valid;
  logic               hit_load;
  hmsu_pkg::hit_t     hit;

  assign proc_fire = item_valid && (!m_axis_tvalid || m_axis_tready);
  assign hit_load  = proc_fire && hit_valid;

  hmsu_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .proc_fire_i   (proc_fire),
    .item_valid_o  (item_valid),
    .item_o        (item)
  );

  hmsu_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .proc_fire_i (proc_fire),
    .item_i      (item),
    .hit_valid_o (hit_valid),
    .hit_o       (hit)
  );

  hmsu_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .hit_load_i    (hit_load),
    .hit_i         (hit),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while parser is blocked");

  a_result_from_parse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(hit_load))
    else $error("result appeared without a parsed hit");

  a_accept_moves_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> item_valid)
    else $error("accepted item lost before parsing");

endmodule

// File: tb/hit_message_stream_unpacker_test.sv
// Self-checking testbench: random slices through the unpacker, hits checked against a predictor.
module hit_message_stream_unpacker_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MIN_ITEMS  = 500;
  localparam int unsigned HOLD_AT    = 300;
  localparam int unsigned HOLD_LEN   = 200;
  localparam int unsigned CALM_FROM  = 40;
  localparam int unsigned CALM_TO    = 240;
  localparam int unsigned DRAIN_CYC  = 20;
  localparam int unsigned MAX_PRINTS = 100;

  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZEROS  = 1;
  localparam int FILL_ONES   = 2;
  localparam int KIND_MIXED  = -1;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [hmsu_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                            s_axis_tuser  = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [hmsu_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  hit_message_stream_unpacker u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  int unsigned cyc = 0;
  always @(posedge clk_i) cyc <= cyc + 1;

  function automatic logic gaps_on();
    return !(cyc >= CALM_FROM && cyc < CALM_TO);
  endfunction

  // unpacker state as the predictor sees it
  hmsu_pkg::phase_e ph         = hmsu_pkg::PH_SKIP;
  int unsigned      slice_off  = 0;
  int unsigned      bytes_left = 0;
  logic [7:0]       msg_buf [5];
  logic [2:0]       msg_idx    = '0;
  logic [15:0]      board      = '0;
  logic [31:0]      epoch      = '0;
  logic [15:0]      equip_reg  = '0;

  hmsu_pkg::hit_t   hits_due [$];
  int unsigned      err_cnt = 0;
  int unsigned      items_total = 0;
  int unsigned      items_done = 0;

  task automatic parse_byte(input hmsu_pkg::in_item_t it);
    hmsu_pkg::hit_t h;
    logic [7:0]     b;
    logic           packet_done;
    b = it.data_byte;
    packet_done = 1'b0;
    if (it.slice_start) begin
      ph = hmsu_pkg::PH_SKIP;
      slice_off = 0;
      bytes_left = 0;
      msg_idx = '0;
      equip_reg = it.equipment_in;
    end
    if (ph == hmsu_pkg::PH_SKIP) begin
      if (bytes_left < hmsu_pkg::SLICE_HEADER_BYTES) begin
        bytes_left++;
      end else begin
        ph = hmsu_pkg::PH_HDR;
        msg_idx = '0;
      end
    end
    if (ph == hmsu_pkg::PH_HDR) begin
      case (msg_idx[1:0])
        2'd0: begin
          bytes_left = 2 * int'(b);
          msg_idx = 3'd1;
        end
        2'd1: msg_idx = 3'd2;
        2'd2: begin
          board[7:0] = b;
          msg_idx = 3'd3;
        end
        default: begin
          board[15:8] = b;
          msg_idx = '0;
          if (bytes_left == 0) packet_done = 1'b1;
          else ph = hmsu_pkg::PH_BODY;
        end
      endcase
    end else if (ph == hmsu_pkg::PH_BODY) begin
      if (msg_idx < 3'd5) begin
        msg_buf[msg_idx] = b;
        msg_idx = msg_idx + 3'd1;
      end else begin
        if (b[3:0] == hmsu_pkg::MSG_HIT) begin
          h.equipment_id    = equip_reg;
          h.source_address  = {board, b[7:6]};
          h.channel         = msg_buf[2][7:1];
          h.hit_epoch       = epoch - {31'b0, msg_buf[0][7]};
          h.timestamp       = {msg_buf[2][0], msg_buf[3], msg_buf[4][7:3]};
          h.adc_value       = {msg_buf[0][4:0], msg_buf[1][7:1]};
          h.last_epoch_flag = msg_buf[0][7];
          h.pileup_flag     = msg_buf[0][5];
          h.overflow_flag   = msg_buf[0][6];
          hits_due.push_back(h);
        end else if (b[3:0] == hmsu_pkg::MSG_EPOCH) begin
          epoch = {msg_buf[1], msg_buf[2], msg_buf[3], msg_buf[4]};
        end
        msg_idx = '0;
      end
      if (bytes_left > 0) bytes_left--;
      if (bytes_left == 0) packet_done = 1'b1;
    end
    slice_off = (slice_off + 1) % hmsu_pkg::PACKET_ALIGN;
    if (packet_done) begin
      ph = (slice_off == 0) ? hmsu_pkg::PH_HDR : hmsu_pkg::PH_PAD;
      msg_idx = '0;
    end else if (ph == hmsu_pkg::PH_PAD && slice_off == 0) begin
      ph = hmsu_pkg::PH_HDR;
      msg_idx = '0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (err_cnt < MAX_PRINTS) $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  task automatic check_hit(input logic [hmsu_pkg::OUT_DATA_W-1:0] raw);
    hmsu_pkg::hit_t got;
    hmsu_pkg::hit_t want;
    got = raw[$bits(hmsu_pkg::hit_t)-1:0];
    if (hits_due.size() == 0) begin
      report_mismatch($sformatf("hit %h with nothing due", raw));
      return;
    end
    want = hits_due.pop_front();
    check_field("equipment_id", 32'(got.equipment_id), 32'(want.equipment_id));
    check_field("source_address", 32'(got.source_address), 32'(want.source_address));
    check_field("channel", 32'(got.channel), 32'(want.channel));
    check_field("hit_epoch", got.hit_epoch, want.hit_epoch);
    check_field("timestamp", 32'(got.timestamp), 32'(want.timestamp));
    check_field("adc_value", 32'(got.adc_value), 32'(want.adc_value));
    check_field("last_epoch_flag", 32'(got.last_epoch_flag), 32'(want.last_epoch_flag));
    check_field("pileup_flag", 32'(got.pileup_flag), 32'(want.pileup_flag));
    check_field("overflow_flag", 32'(got.overflow_flag), 32'(want.overflow_flag));
    check_field("zero fill", 32'(raw[hmsu_pkg::OUT_DATA_W-1:$bits(hmsu_pkg::hit_t)]), '0);
  endtask

  // slice builder
  hmsu_pkg::in_item_t bytes_to_send [$];
  hmsu_pkg::in_item_t slice_q [$];
  int unsigned        big_cnt = 0;

  task automatic push_byte(input logic [7:0] b);
    slice_q.push_back('{equipment_in: 16'($urandom), slice_start: 1'b0, data_byte: b});
  endtask

  task automatic slice_open(input logic marked, input logic [15:0] equip);
    slice_q.delete();
    slice_q.push_back('{equipment_in: equip, slice_start: marked, data_byte: 8'($urandom)});
    repeat (hmsu_pkg::SLICE_HEADER_BYTES - 1) push_byte(8'($urandom));
  endtask

  task automatic add_packet(input int unsigned len, input logic [15:0] brd, input int fill,
                            input int kind);
    logic [7:0] b;
    logic [3:0] t;
    int unsigned r;
    push_byte(8'(len));
    push_byte(8'($urandom));
    push_byte(brd[7:0]);
    push_byte(brd[15:8]);
    for (int i = 0; i < 2 * len; i++) begin
      if (fill == FILL_ONES) b = 8'hFF;
      else if (fill == FILL_ZEROS) b = 8'h00;
      else b = 8'($urandom);
      if (i % 6 == 5) begin
        if (kind >= 0) begin
          t = 4'(kind);
        end else begin
          r = $urandom_range(99);
          t = (r < 60) ? hmsu_pkg::MSG_HIT : (r < 80) ? hmsu_pkg::MSG_EPOCH : 4'($urandom);
        end
        b[3:0] = t;
      end
      push_byte(b);
    end
    while (slice_q.size() % hmsu_pkg::PACKET_ALIGN != 0) push_byte(8'($urandom));
  endtask

  task automatic slice_close(input int unsigned keep);
    for (int unsigned i = 0; i < keep; i++) bytes_to_send.push_back(slice_q[i]);
  endtask

  task automatic add_random_slice();
    int unsigned npk;
    int unsigned len;
    int unsigned r;
    slice_open(1'b1, 16'($urandom));
    npk = $urandom_range(1, 6);
    repeat (npk) begin
      r = $urandom_range(99);
      if (r < 50) begin
        len = 3 * $urandom_range(1, 3);
      end else if (r < 62) begin
        len = 0;
      end else if (r < 82) begin
        len = $urandom_range(1, 10);
      end else if (r < 97 || big_cnt >= 1) begin
        len = $urandom_range(11, 40);
      end else begin
        len = $urandom_range(100, 255);
        big_cnt++;
      end
      add_packet(len, 16'($urandom), FILL_RANDOM, KIND_MIXED);
    end
    if ($urandom_range(99) < 15) slice_close($urandom_range(1, slice_q.size() - 1));
    else slice_close(slice_q.size());
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 8)) begin
        bytes_to_send.push_back('{16'($urandom), $urandom_range(99) < 30, 8'($urandom)});
      end
    end
  endtask

  // driver
  hmsu_pkg::in_item_t on_bus;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(on_bus);
        items_done++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (bytes_to_send.size() != 0 && !(gaps_on() && $urandom_range(99) < 25)) begin
          on_bus = bytes_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {on_bus.equipment_in, on_bus.data_byte};
          s_axis_tuser  <= on_bus.slice_start;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int unsigned hold_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_hit(m_axis_tdata);
      if (cyc == HOLD_AT) hold_left = HOLD_LEN;
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(gaps_on() && $urandom_range(99) < 25);
      end
    end
  end

  initial begin
    // first slice runs unmarked from reset
    slice_open(1'b0, 16'h0000);
    add_packet(0, 16'h0000, FILL_ZEROS, hmsu_pkg::MSG_HIT);
    add_packet(5, 16'hFFFF, FILL_ONES, hmsu_pkg::MSG_HIT);
    add_packet(3, 16'h0000, FILL_ONES, hmsu_pkg::MSG_EPOCH);
    add_packet(3, 16'h8001, FILL_ZEROS, hmsu_pkg::MSG_HIT);
    slice_close(slice_q.size());
    while (bytes_to_send.size() < MIN_ITEMS) add_random_slice();
    items_total = bytes_to_send.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (items_done != items_total);
    do @(posedge clk_i); while (hits_due.size() != 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/hmsu_pkg.sv
hw/rtl/hmsu_in_stage.sv
hw/rtl/hmsu_parser.sv
hw/rtl/hmsu_out_stage.sv
hw/rtl/hit_message_stream_unpacker.sv
tb/hit_message_stream_unpacker_test.sv
